@@ design/bank_switch_mapper_with_scanline_irq_assert.svh @@
// Assertion macros shared by the mapper RTL.
// Each macro expects clk and rst in scope of the module that uses it.
`ifndef BANK_SWITCH_MAPPER_WITH_SCANLINE_IRQ_ASSERT_SVH
`define BANK_SWITCH_MAPPER_WITH_SCANLINE_IRQ_ASSERT_SVH

// Same-cycle implication.
`define BSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bsm_pkg.sv @@
// Shared types and codes for the bank-switch mapper.
// No dependencies; imported by bsm_irq and the top level.
`timescale 1ns / 1ps

package bsm_pkg;

  // Bus event kinds carried on the input tuser.
  typedef enum logic [2:0] {
    FN_CPU_WRITE = 3'd0,
    FN_PRG_READ  = 3'd1,
    FN_PPU_READ  = 3'd2,
    FN_TICK      = 3'd3,
    FN_IRQ_ACK   = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    TGT_NONE    = 2'd0,
    TGT_PRG_ROM = 2'd1,
    TGT_PRG_RAM = 2'd2,
    TGT_PATTERN = 2'd3
  } target_t;

  typedef enum logic [1:0] {
    MIR_HORIZONTAL = 2'd0,
    MIR_VERTICAL   = 2'd1,
    MIR_FOUR       = 2'd2
  } mirror_t;

  // Configuration register indexes.
  localparam logic CFG_PRG_COUNT   = 1'b0;
  localparam logic CFG_FOUR_SCREEN = 1'b1;

  // CPU register regions, address bits [14:13] above 0x8000.
  localparam logic [1:0] REG_BANK      = 2'd0;
  localparam logic [1:0] REG_MIRROR    = 2'd1;
  localparam logic [1:0] REG_IRQ_LATCH = 2'd2;
  localparam logic [1:0] REG_IRQ_EN    = 2'd3;

  // Bank data targets selected by bank_select[2:0].
  localparam logic [2:0] SEL_PRG_SWAP = 3'd6;
  localparam logic [2:0] SEL_PRG_MID  = 3'd7;

  localparam logic [7:0] PRG_COUNT_RESET = 8'd64;

  // Per-transfer strobes into the scanline interrupt unit.
  typedef struct packed {
    logic tick;
    logic latch_wr;
    logic reload_wr;
    logic disable_wr;
    logic enable_wr;
    logic ack;
  } irq_ctrl_t;

endpackage

@@ design/bsm_irq.sv @@
// Scanline interrupt counter: latch, reload request, enable and pending flag.
// Depends on bsm_pkg and the assertion macro header.
`timescale 1ns / 1ps

module bsm_irq (
  input  logic              clk,
  input  logic              rst,
  input  bsm_pkg::irq_ctrl_t ctrl,
  input  logic [7:0]        latch_value,
  output logic              flag
);
  import bsm_pkg::*;
  `include "bank_switch_mapper_with_scanline_irq_assert.svh"

  logic [7:0] latch,   latch_next;
  logic [7:0] counter, counter_next;
  logic       reload,  reload_next;
  logic       enabled, enabled_next;
  logic       pending, pending_next;
  logic [7:0] dec;
  logic       reload_hit;

  always_comb begin
    latch_next   = latch;
    counter_next = counter;
    reload_next  = reload;
    enabled_next = enabled;
    flag         = pending;
    dec          = counter - 8'd1;
    reload_hit   = reload;

    if (ctrl.latch_wr) begin
      latch_next = latch_value;
    end
    if (ctrl.reload_wr) begin
      reload_next = 1'b1;
    end
    if (ctrl.disable_wr) begin
      enabled_next = 1'b0;
      flag         = 1'b0;
    end
    if (ctrl.enable_wr) begin
      enabled_next = 1'b1;
    end
    if (ctrl.tick) begin
      counter_next = dec;
      if (dec == 8'd0) begin
        if (enabled) begin
          flag = 1'b1;
        end
        reload_hit = 1'b1;
      end
      if (reload_hit) begin
        counter_next = latch;
        reload_next  = 1'b0;
      end
    end
    // flag is reported before an acknowledge clears it
    pending_next = flag & ~ctrl.ack;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latch   <= 8'd0;
      counter <= 8'd0;
      reload  <= 1'b0;
      enabled <= 1'b0;
      pending <= 1'b0;
    end else begin
      latch   <= latch_next;
      counter <= counter_next;
      reload  <= reload_next;
      enabled <= enabled_next;
      pending <= pending_next;
    end
  end

  `BSM_ASSERT_NEXT(a_ack_clears, ctrl.ack, !pending, "irq pending survived acknowledge")
  `BSM_ASSERT_NEXT(a_disable_clears, ctrl.disable_wr, !pending && !enabled,
    "irq disable left pending or enabled set")
  `BSM_ASSERT_NEXT(a_tick_fires, ctrl.tick && !ctrl.ack && enabled && counter == 8'd1,
    pending, "counter reached zero while enabled without raising irq")

endmodule

@@ design/bank_switch_mapper_with_scanline_irq.sv @@
// Cartridge bank-switch mapper with a scanline interrupt counter. Every bus
// event arrives as one transfer on the s_ group (tuser = event kind) and
// yields exactly one result transfer on the m_ group in the cycle after acceptance: the
// translated target and byte offset, the interrupt flag and the current
// nametable mirroring. One event is taken every clock cycle while s_tready is high; the only
// storage between the two sides is the result register, so s_tready drops
// only while that register holds a result that m_tready does not take.
// Bank tables and IRQ state update at the accepting edge, so the next event
// already sees them. Config writes (prg_bank_count, quad_screen) go through
// the cfg_ port and are applied at once. Depends on bsm_pkg, bsm_irq.
`timescale 1ns / 1ps

module bank_switch_mapper_with_scanline_irq (
  input  logic        clk,
  input  logic        rst,
  // input events
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] address, [23:16] value
  input  logic [2:0]  s_tuser,   // [2:0] func
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] mem_offset, [21] irq_flag, [23:22] mirroring
  output logic [1:0]  m_tuser,   // [1:0] target
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import bsm_pkg::*;
  `include "bank_switch_mapper_with_scanline_irq_assert.svh"

  // Mapper state
  logic [7:0] prg_bank_count, prg_bank_count_next;
  logic       quad_screen,    quad_screen_next;
  logic [7:0] bank_select,    bank_select_next;
  logic [7:0] prg_bank [4];
  logic [7:0] prg_bank_next [4];
  logic [7:0] chr_bank [8];
  logic [7:0] chr_bank_next [8];
  mirror_t    mirror,         mirror_next;

  // Input decode
  logic        accept;
  func_t       fn;
  logic [15:0] addr;
  logic [7:0]  val;
  logic [7:0]  second_last;
  logic [7:0]  cfg_second_last;
  logic [2:0]  sel;
  logic [2:0]  chr_base;
  logic [2:0]  slot;
  logic [2:0]  slot_odd;

  // Result
  target_t     target;
  logic [20:0] offset;
  logic        irq_flag;
  irq_ctrl_t   irq_ctrl;

  assign accept          = s_tvalid & s_tready;
  assign s_tready        = ~m_tvalid | m_tready;
  assign fn              = func_t'(s_tuser);
  assign addr            = s_tdata[15:0];
  assign val             = s_tdata[23:16];
  assign second_last     = prg_bank_count - 8'd2;
  assign cfg_second_last = cfg_data - 8'd2;
  assign sel             = bank_select[2:0];
  // 2KB pattern pairs live in the half chosen by bank_select[7]
  assign chr_base        = bank_select[7] ? 3'd4 : 3'd0;
  assign slot            = chr_base + {sel[1:0], 1'b0};
  assign slot_odd        = slot + 3'd1;

  always_comb begin
    prg_bank_count_next = prg_bank_count;
    quad_screen_next    = quad_screen;
    bank_select_next    = bank_select;
    prg_bank_next       = prg_bank;
    chr_bank_next       = chr_bank;
    mirror_next         = mirror;
    irq_ctrl            = '0;
    target              = TGT_NONE;
    offset              = '0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_PRG_COUNT: begin
          // refresh the fixed windows for the current mode
          prg_bank_count_next = cfg_data;
          if (bank_select[6]) begin
            prg_bank_next[0] = cfg_second_last;
          end else begin
            prg_bank_next[2] = cfg_second_last;
          end
          prg_bank_next[3] = cfg_data - 8'd1;
        end
        CFG_FOUR_SCREEN: begin
          quad_screen_next = cfg_data[0];
          if (cfg_data[0]) begin
            mirror_next = MIR_FOUR;
          end else if (mirror == MIR_FOUR) begin
            mirror_next = MIR_HORIZONTAL;
          end
        end
        default: ;
      endcase
    end

    if (accept) begin
      case (fn)
        FN_CPU_WRITE, FN_PRG_READ: begin
          if (addr[15:13] == 3'b011) begin
            // PRG-RAM window, reads and writes alike
            target = TGT_PRG_RAM;
            offset = {8'd0, addr[12:0]};
          end else if (addr[15] && fn == FN_PRG_READ) begin
            target = TGT_PRG_ROM;
            offset = {prg_bank[addr[14:13]], addr[12:0]};
          end else if (addr[15]) begin
            case (addr[14:13])
              REG_BANK: begin
                if (!addr[0]) begin
                  // bank select: a mode flip regroups the stored banks
                  if (bank_select[6] != val[6]) begin
                    if (val[6]) begin
                      prg_bank_next[0] = second_last;
                      prg_bank_next[2] = prg_bank[0];
                    end else begin
                      prg_bank_next[0] = prg_bank[2];
                      prg_bank_next[2] = second_last;
                    end
                    prg_bank_next[3] = prg_bank_count - 8'd1;
                  end
                  if (bank_select[7] != val[7]) begin
                    for (int i = 0; i < 4; i++) begin
                      chr_bank_next[i]     = chr_bank[i + 4];
                      chr_bank_next[i + 4] = chr_bank[i];
                    end
                  end
                  bank_select_next = val;
                end else begin
                  // bank data into the window named by bank_select
                  case (sel)
                    SEL_PRG_MID: prg_bank_next[1] = val;
                    SEL_PRG_SWAP: begin
                      if (bank_select[6]) begin
                        prg_bank_next[2] = val;
                      end else begin
                        prg_bank_next[0] = val;
                      end
                    end
                    3'd0, 3'd1: begin
                      chr_bank_next[slot]     = {val[7:1], 1'b0};
                      chr_bank_next[slot_odd] = {val[7:1], 1'b1};
                    end
                    default: begin
                      chr_bank_next[(chr_base ^ 3'd4) + (sel - 3'd2)] = val;
                    end
                  endcase
                end
              end
              REG_MIRROR: begin
                if (!addr[0]) begin
                  if (quad_screen) begin
                    mirror_next = MIR_FOUR;
                  end else begin
                    mirror_next = val[0] ? MIR_HORIZONTAL : MIR_VERTICAL;
                  end
                end
              end
              REG_IRQ_LATCH: begin
                irq_ctrl.latch_wr  = ~addr[0];
                irq_ctrl.reload_wr = addr[0];
              end
              REG_IRQ_EN: begin
                irq_ctrl.disable_wr = ~addr[0];
                irq_ctrl.enable_wr  = addr[0];
              end
              default: ;
            endcase
          end
        end
        FN_PPU_READ: begin
          target = TGT_PATTERN;
          offset = {3'd0, chr_bank[addr[12:10]], addr[9:0]};
        end
        FN_TICK:    irq_ctrl.tick = 1'b1;
        FN_IRQ_ACK: irq_ctrl.ack  = 1'b1;
        default: ;
      endcase
    end
  end

  bsm_irq u_irq (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (irq_ctrl),
    .latch_value (val),
    .flag        (irq_flag)
  );

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= PRG_COUNT_RESET;
      quad_screen    <= 1'b0;
      bank_select    <= 8'd0;
      prg_bank[0]    <= 8'd0;
      prg_bank[1]    <= 8'd1;
      prg_bank[2]    <= PRG_COUNT_RESET - 8'd2;
      prg_bank[3]    <= PRG_COUNT_RESET - 8'd1;
      for (int i = 0; i < 8; i++) begin
        chr_bank[i] <= 8'(i);
      end
      mirror <= MIR_HORIZONTAL;
    end else begin
      prg_bank_count <= prg_bank_count_next;
      quad_screen    <= quad_screen_next;
      bank_select    <= bank_select_next;
      prg_bank       <= prg_bank_next;
      chr_bank       <= chr_bank_next;
      mirror         <= mirror_next;
    end
  end

  // result register: valid under reset, payload loads on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tuser <= target;
      m_tdata <= {mirror_next, irq_flag, offset};
    end
  end

  `BSM_ASSERT_NOW(a_quad_screen_mirror, quad_screen, mirror == MIR_FOUR,
    "four-screen wiring not reflected in mirroring")
  `BSM_ASSERT_NOW(a_none_zero_offset, m_tvalid && m_tuser == TGT_NONE,
    m_tdata[20:0] == 21'd0, "nonzero offset with no target")
  `BSM_ASSERT_NOW(a_ram_in_window, m_tvalid && m_tuser == TGT_PRG_RAM,
    m_tdata[20:13] == 8'd0, "program RAM offset outside 8KB window")

endmodule

@@ dv/bank_switch_mapper_with_scanline_irq_tb.sv @@
// Self-checking testbench for bank_switch_mapper_with_scanline_irq.
// Holds its own mapper/IRQ predictor and checks every result transfer in order.
// Depends on bsm_pkg and the mapper RTL only.
`timescale 1ns / 1ps

module bank_switch_mapper_with_scanline_irq_tb;
  import bsm_pkg::*;

  // Event kinds the block must ignore (no name in the package).
  localparam logic [2:0] FN_RESERVED_MIN = 3'd5;
  localparam logic [2:0] FN_RESERVED_MAX = 3'd7;
  // Bank data selects below this one load a 2KB pattern pair.
  localparam logic [2:0] SEL_CHR_1K_FIRST = 3'd2;
  // Cycles with no transfer on either side before the run is abandoned.
  localparam int QUIET_LIMIT = 2000;
  // Length of the deliberate receiver hold-off.
  localparam int LONG_HOLD = 300;

  // One translated bus event, as the block reports it.
  typedef struct packed {
    target_t     target;
    logic [20:0] offset;
    logic        irq;
    mirror_t     mirroring;
  } xlat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [15:0] address, [23:16] value
  logic [2:0]  s_tuser = '0;   // [2:0] func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [20:0] mem_offset, [21] irq_flag, [23:22] mirroring
  logic [1:0]  m_tuser;        // [1:0] target
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = '0;

  bank_switch_mapper_with_scanline_irq uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: configuration, bank tables, scanline counter, IRQ bits.
  // ---------------------------------------------------------------------------
  logic [7:0] bank_count;
  logic       four_wired;
  logic [7:0] sel_reg;
  logic [7:0] prg_win [4];
  logic [7:0] chr_win [8];
  logic [7:0] irq_latch;
  logic [7:0] line_count;
  logic       reload_req;
  logic       irq_en;
  logic       irq_pend;
  mirror_t    mir;

  xlat_t xlat_q[$];      // expected translations, oldest first
  int    mismatches = 0;
  logic  idle_on = 1'b1; // random gaps on both sides
  logic  rx_long_req = 1'b0;
  int    rx_hold = 0;
  int    quiet_cycles = 0;

  task automatic reset_mapper_state();
    bank_count = PRG_COUNT_RESET;
    four_wired = 1'b0;
    sel_reg    = '0;
    prg_win[0] = 8'd0;
    prg_win[1] = 8'd1;
    prg_win[2] = bank_count - 8'd2;
    prg_win[3] = bank_count - 8'd1;
    for (int i = 0; i < 8; i++) chr_win[i] = 8'(i);
    irq_latch  = '0;
    line_count = '0;
    reload_req = 1'b0;
    irq_en     = 1'b0;
    irq_pend   = 1'b0;
    mir        = MIR_HORIZONTAL;
  endtask

  // Bank select write: a flip of bit 6 swaps which 8KB window is fixed to the
  // second-last bank, a flip of bit 7 swaps the two pattern halves.
  task automatic select_banks(input logic [7:0] v);
    logic [7:0] p [4];
    logic [7:0] c [8];
    p = prg_win;
    c = chr_win;
    if (sel_reg[6] != v[6]) begin
      if (v[6]) begin
        prg_win[0] = bank_count - 8'd2;
        prg_win[2] = p[0];
      end else begin
        prg_win[0] = p[2];
        prg_win[2] = bank_count - 8'd2;
      end
      prg_win[3] = bank_count - 8'd1;
    end
    if (sel_reg[7] != v[7]) begin
      for (int i = 0; i < 4; i++) begin
        chr_win[i]     = c[i + 4];
        chr_win[i + 4] = c[i];
      end
    end
    sel_reg = v;
  endtask

  // Bank data write into the window that bank select points at.
  task automatic load_bank(input logic [7:0] v);
    logic [2:0] r;
    logic [2:0] slot;
    logic [7:0] even;
    r    = sel_reg[2:0];
    even = v & 8'hFE;
    if (r == SEL_PRG_MID) begin
      prg_win[1] = v;
    end else if (r == SEL_PRG_SWAP) begin
      prg_win[sel_reg[6] ? 2 : 0] = v;
    end else if (r < SEL_CHR_1K_FIRST) begin
      // 2KB pair: even bank then its odd neighbour
      slot = {sel_reg[7], r[0], 1'b0};
      chr_win[slot]        = even;
      chr_win[slot + 3'd1] = even + 8'd1;
    end else begin
      chr_win[{~sel_reg[7], 2'(r - SEL_CHR_1K_FIRST)}] = v;
    end
  endtask

  task automatic write_mapper_reg(input logic [15:0] addr, input logic [7:0] v);
    case (addr[14:13])
      REG_BANK: begin
        if (addr[0]) load_bank(v);
        else select_banks(v);
      end
      REG_MIRROR: begin
        if (!addr[0]) mir = four_wired ? MIR_FOUR : (v[0] ? MIR_HORIZONTAL : MIR_VERTICAL);
      end
      REG_IRQ_LATCH: begin
        if (addr[0]) reload_req = 1'b1;
        else irq_latch = v;
      end
      default: begin
        // REG_IRQ_EN: odd enables, even disables and acknowledges
        if (addr[0]) begin
          irq_en = 1'b1;
        end else begin
          irq_en   = 1'b0;
          irq_pend = 1'b0;
        end
      end
    endcase
  endtask

  // Scanline tick: count down, raise the IRQ on zero, then take any reload.
  task automatic count_scanline();
    line_count = line_count - 8'd1;
    if (line_count == 8'd0) begin
      if (irq_en) irq_pend = 1'b1;
      reload_req = 1'b1;
    end
    if (reload_req) begin
      line_count = irq_latch;
      reload_req = 1'b0;
    end
  endtask

  // Translate one bus event and advance the mapper state.
  task automatic translate_event(input logic [2:0] fn, input logic [15:0] addr,
                                 input logic [7:0] val, output xlat_t r);
    logic [12:0] pa;
    r.target = TGT_NONE;
    r.offset = '0;
    pa = addr[12:0];
    case (fn)
      FN_CPU_WRITE, FN_PRG_READ: begin
        if (addr >= 16'h6000 && addr < 16'h8000) begin
          r.target = TGT_PRG_RAM;
          r.offset = 21'(addr - 16'h6000);
        end else if (addr[15]) begin
          if (fn == FN_CPU_WRITE) begin
            write_mapper_reg(addr, val);
          end else begin
            r.target = TGT_PRG_ROM;
            r.offset = {prg_win[addr[14:13]], addr[12:0]};
          end
        end
      end
      FN_PPU_READ: begin
        r.target = TGT_PATTERN;
        r.offset = {3'b000, chr_win[pa[12:10]], pa[9:0]};
      end
      FN_TICK: count_scanline();
      default: ;
    endcase
    r.irq = irq_pend;
    if (fn == FN_IRQ_ACK) irq_pend = 1'b0;
    r.mirroring = mir;
  endtask

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one event, wait for the transfer, queue its expected translation.
  // Valid stays high for back-to-back events; it drops only for a gap or a drain.
  task automatic send_event(input logic [2:0] fn, input logic [15:0] addr,
                            input logic [7:0] val);
    xlat_t r;
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {val, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    translate_event(fn, addr, val, r);
    xlat_q.push_back(r);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every queued result has been checked.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (xlat_q.size() != 0) @(posedge clk);
  endtask

  // Only called with the block drained.
  task automatic write_config(input logic idx, input logic [7:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PRG_COUNT) begin
      bank_count = d;
      if (sel_reg[6]) prg_win[0] = bank_count - 8'd2;
      else prg_win[2] = bank_count - 8'd2;
      prg_win[3] = bank_count - 8'd1;
    end else begin
      four_wired = d[0];
      if (four_wired) mir = MIR_FOUR;
      else if (mir == MIR_FOUR) mir = MIR_HORIZONTAL;
    end
    @(posedge clk);
  endtask

  // CPU address of a mapper register with random don't-care bits.
  function automatic logic [15:0] reg_addr(input logic [1:0] region, input logic odd);
    return {1'b1, region, 12'($urandom), odd};
  endfunction

  // Random event mix: mostly register writes, reads and pattern fetches.
  task automatic send_random_event();
    int unsigned pick;
    logic [15:0] addr;
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      send_event(FN_CPU_WRITE, reg_addr(2'($urandom), 1'($urandom)), 8'($urandom));
    end else if (pick < 33) begin
      send_event(FN_CPU_WRITE, 16'($urandom), 8'($urandom));
    end else if (pick < 55) begin
      send_event(FN_PRG_READ, 16'($urandom), 8'($urandom));
    end else if (pick < 78) begin
      addr = $urandom_range(0, 1) ? {3'b000, 13'($urandom)} : 16'($urandom);
      send_event(FN_PPU_READ, addr, 8'($urandom));
    end else if (pick < 93) begin
      send_event(FN_TICK, 16'($urandom), 8'($urandom));
    end else if (pick < 98) begin
      send_event(FN_IRQ_ACK, 16'($urandom), 8'($urandom));
    end else begin
      send_event(3'($urandom_range(FN_RESERVED_MIN, FN_RESERVED_MAX)), 16'($urandom),
                 8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random short stalls, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold  <= rx_hold - 1;
      m_tready <= 1'b0;
    end else if (rx_long_req) begin
      rx_long_req <= 1'b0;
      rx_hold     <= LONG_HOLD - 1;
      m_tready    <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_hold  <= $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking against the oldest expectation.
  // ---------------------------------------------------------------------------
  function automatic void note_mismatch(input string what, input logic [20:0] want_v,
                                        input logic [20:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, what, want_v, got_v);
  endfunction

  xlat_t want;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (xlat_q.size() == 0) begin
        note_mismatch("unexpected result", '0, m_tdata[20:0]);
      end else begin
        want = xlat_q.pop_front();
        if (m_tuser !== want.target) note_mismatch("target", want.target, m_tuser);
        if (m_tdata[20:0] !== want.offset) note_mismatch("mem_offset", want.offset,
                                                          m_tdata[20:0]);
        if (m_tdata[21] !== want.irq) note_mismatch("irq_flag", want.irq, m_tdata[21]);
        if (m_tdata[23:22] !== want.mirroring) note_mismatch("mirroring", want.mirroring,
                                                              m_tdata[23:22]);
      end
    end
  end

  // Watchdog: too long with no transfer on either side means a hang.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Address extremes, every event kind, mode flips and one IRQ round trip.
  task automatic test_directed();
    send_event(FN_PRG_READ, 16'h8000, 8'h00);   // first window, bank 0
    send_event(FN_PRG_READ, 16'hFFFF, 8'hFF);   // last byte of the last bank
    send_event(FN_PRG_READ, 16'hC000, 8'h00);   // second-last bank
    send_event(FN_PRG_READ, 16'h6000, 8'h00);   // program RAM bottom
    send_event(FN_CPU_WRITE, 16'h7FFF, 8'hA5);  // program RAM top
    send_event(FN_PRG_READ, 16'h0000, 8'h00);   // below 0x6000: nothing
    send_event(FN_CPU_WRITE, 16'h5FFF, 8'hFF);
    send_event(FN_PPU_READ, 16'h0000, 8'h00);
    send_event(FN_PPU_READ, 16'h1FFF, 8'h00);
    send_event(FN_PPU_READ, 16'hFFFF, 8'h00);   // only low 13 bits count
    send_event(FN_CPU_WRITE, 16'h8000, 8'hC6);  // flip both mode bits, select swap bank
    send_event(FN_CPU_WRITE, 16'h8001, 8'hFF);
    send_event(FN_PRG_READ, 16'hC123, 8'h00);
    send_event(FN_CPU_WRITE, 16'h8000, 8'h80);  // 2KB pattern pair, odd value
    send_event(FN_CPU_WRITE, 16'h8001, 8'hFF);
    send_event(FN_PPU_READ, 16'h1400, 8'h00);
    send_event(FN_CPU_WRITE, 16'hA000, 8'h00);  // vertical
    send_event(FN_CPU_WRITE, 16'hA001, 8'h01);  // odd mirror address is ignored
    send_event(FN_CPU_WRITE, 16'hC000, 8'h02);  // latch
    send_event(FN_CPU_WRITE, 16'hC001, 8'h00);  // reload
    send_event(FN_CPU_WRITE, 16'hE001, 8'h00);  // enable
    repeat (3) send_event(FN_TICK, 16'h0000, 8'h00);
    send_event(FN_IRQ_ACK, 16'h0000, 8'h00);    // reports the raised flag
    send_event(FN_IRQ_ACK, 16'hFFFF, 8'hFF);
    send_event(FN_CPU_WRITE, 16'hE000, 8'h00);  // disable
    send_event(FN_RESERVED_MIN, 16'h8000, 8'h00);
    send_event(FN_RESERVED_MAX, 16'hFFFF, 8'hFF);
  endtask

  // Bank counts at and past the extremes, four-screen on and off.
  task automatic test_config_sweep();
    logic [7:0] counts [8];
    counts = '{8'd2, 8'd255, 8'd0, 8'd1, 8'd3, 8'($urandom_range(2, 255)), 8'd128,
               PRG_COUNT_RESET};
    for (int k = 0; k < 8; k++) begin
      drain_results();
      write_config(CFG_PRG_COUNT, counts[k]);
      write_config(CFG_FOUR_SCREEN, {7'd0, 1'(k % 3 == 1)});
      send_event(FN_PRG_READ, 16'hE000 | 16'($urandom_range(0, 8191)), 8'h00);
      repeat (40) send_random_event();
    end
    drain_results();
    write_config(CFG_FOUR_SCREEN, 8'd0);
  endtask

  // Well-formed IRQ setups: latch, reload, enable (most runs), ticks past the latch value, ack.
  task automatic test_irq_sequences();
    int unsigned n;
    for (int s = 0; s < 30; s++) begin
      n = $urandom_range(0, 6);
      send_event(FN_CPU_WRITE, reg_addr(REG_IRQ_LATCH, 1'b0), 8'(n));
      send_event(FN_CPU_WRITE, reg_addr(REG_IRQ_LATCH, 1'b1), 8'($urandom));
      if ($urandom_range(0, 3) != 0)
        send_event(FN_CPU_WRITE, reg_addr(REG_IRQ_EN, 1'b1), 8'($urandom));
      repeat (n + 2) begin
        send_event(FN_TICK, 16'($urandom), 8'($urandom));
        if ($urandom_range(0, 2) == 0) send_random_event();
      end
      if ($urandom_range(0, 3) == 0)
        send_event(FN_CPU_WRITE, reg_addr(REG_IRQ_EN, 1'b0), 8'($urandom));
      send_event(FN_IRQ_ACK, 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_random_mix();
    repeat (900) send_random_event();
  endtask

  // Receiver holds off while the sender keeps offering, so s_tready drops;
  // afterwards the sender waits for every outstanding result.
  task automatic test_backpressure();
    idle_on     = 1'b0;
    rx_long_req <= 1'b1;
    repeat (40) send_random_event();
    drain_results();
    idle_on = 1'b1;
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    repeat (200) send_random_event();
  endtask

  initial begin
    reset_mapper_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_sweep();
    test_irq_sequences();
    test_random_mix();
    test_backpressure();
    test_no_idle();
    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
